[src/mrtu_pkg.sv]
package mrtu_pkg;

    // Frame limits and register map
    localparam int unsigned MAX_FRAME_DEF = 256;
    localparam int unsigned APB_ADDR_W    = 2;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [APB_ADDR_W-1:0] REG_OWN_ADDRESS = 2'd0;
    localparam logic [7:0]            OWN_ADDR_RST    = 8'h01;

    // CRC-16 (Modbus) constants
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_JSON = 8'h64;
    localparam logic [7:0]  ADDR_BCAST = 8'h00;

    typedef enum logic [2:0] {
        ST_JSON_OK  = 3'd0,
        ST_OTHER_OK = 3'd1,
        ST_CRC_ERR  = 3'd2,
        ST_NOT_ADDR = 3'd3,
        ST_SHORT    = 3'd4
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  function_code;
        logic        is_broadcast;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic [7:0]  payload_length;
        logic [8:0]  frame_length;
    } t_result;

    // One byte through the reflected CRC, unrolled over eight bit steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[src/mrtu_apb_regs.sv]
module mrtu_apb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mrtu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mrtu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mrtu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [7:0]                       o_own_address
);

    logic [7:0] r_own_address;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Write the own address on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= mrtu_pkg::OWN_ADDR_RST;
        end else if (w_wr && (paddr == mrtu_pkg::REG_OWN_ADDRESS)) begin
            r_own_address <= pwdata[7:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr == mrtu_pkg::REG_OWN_ADDRESS) begin
            prdata = {{(mrtu_pkg::APB_DATA_W-8){1'b0}}, r_own_address};
        end
    end

    assign o_own_address = r_own_address;

endmodule

[src/mrtu_frame_core.sv]
module mrtu_frame_core #(
    parameter int unsigned MAX_FRAME = mrtu_pkg::MAX_FRAME_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_end_of_frame,
    input  logic [7:0]           i_own_address,
    output mrtu_pkg::t_result    o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

    logic [15:0]      r_crc,   n_crc;
    logic [7:0]       r_recent, n_recent;
    logic [7:0]       r_older,  n_older;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [7:0]       r_addr,   n_addr;
    logic [7:0]       r_func,   n_func;

    logic [15:0]      w_crc;
    logic [7:0]       w_recent, w_older, w_addr, w_func;
    logic [CNT_W-1:0] w_count;
    logic [15:0]      w_rcv;
    logic [CNT_W-1:0] w_pay_full;

    // Take the byte into the frame state unless the buffer is full
    always_comb begin
        w_crc    = r_crc;
        w_recent = r_recent;
        w_older  = r_older;
        w_count  = r_count;
        w_addr   = r_addr;
        w_func   = r_func;
        if (32'(r_count) < MAX_FRAME) begin
            if (r_count == CNT_W'(0)) begin
                w_addr = i_rx_byte;
            end else if (r_count == CNT_W'(1)) begin
                w_func = i_rx_byte;
            end
            if (r_count >= CNT_W'(2)) begin
                w_crc = mrtu_pkg::crc_feed(r_crc, r_older);
            end
            w_older  = r_recent;
            w_recent = i_rx_byte;
            w_count  = r_count + CNT_W'(1);
        end
    end

    // Build the frame report from the updated state
    assign w_rcv      = {w_recent, w_older};
    assign w_pay_full = w_count - CNT_W'(4);

    always_comb begin
        o_result = '0;
        if (32'(w_count) < 32'd3) begin
            o_result.status = mrtu_pkg::ST_SHORT;
        end else if ((w_addr != i_own_address) && (w_addr != mrtu_pkg::ADDR_BCAST)) begin
            o_result.status = mrtu_pkg::ST_NOT_ADDR;
        end else if (w_rcv != w_crc) begin
            o_result.status = mrtu_pkg::ST_CRC_ERR;
        end else if (w_func == mrtu_pkg::FUNC_JSON) begin
            o_result.status = mrtu_pkg::ST_JSON_OK;
        end else begin
            o_result.status = mrtu_pkg::ST_OTHER_OK;
        end
        o_result.function_code = w_func;
        o_result.is_broadcast  = (w_addr == mrtu_pkg::ADDR_BCAST);
        o_result.received_crc  = w_rcv;
        o_result.computed_crc  = w_crc;
        if (32'(w_count) <= 32'd4) begin
            o_result.payload_length = 8'd0;
        end else if (32'(w_pay_full) > 32'd255) begin
            o_result.payload_length = 8'd255;
        end else begin
            o_result.payload_length = 8'(w_pay_full);
        end
        if (32'(w_count) > 32'd511) begin
            o_result.frame_length = 9'd511;
        end else begin
            o_result.frame_length = 9'(w_count);
        end
    end

    // Advance on each byte; clear the frame after its last byte
    always_comb begin
        n_crc    = r_crc;
        n_recent = r_recent;
        n_older  = r_older;
        n_count  = r_count;
        n_addr   = r_addr;
        n_func   = r_func;
        if (i_step) begin
            if (i_end_of_frame) begin
                n_crc    = mrtu_pkg::CRC_INIT;
                n_recent = 8'd0;
                n_older  = 8'd0;
                n_count  = '0;
                n_addr   = 8'd0;
                n_func   = 8'd0;
            end else begin
                n_crc    = w_crc;
                n_recent = w_recent;
                n_older  = w_older;
                n_count  = w_count;
                n_addr   = w_addr;
                n_func   = w_func;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= mrtu_pkg::CRC_INIT;
            r_recent <= 8'd0;
            r_older  <= 8'd0;
            r_count  <= '0;
            r_addr   <= 8'd0;
            r_func   <= 8'd0;
        end else begin
            r_crc    <= n_crc;
            r_recent <= n_recent;
            r_older  <= n_older;
            r_count  <= n_count;
            r_addr   <= n_addr;
            r_func   <= n_func;
        end
    end

endmodule

[src/modbus_rtu_frame_checker.sv]
// Channel | Direction | Handshake                   | Payload
// rx      | in        | i_in_valid / o_in_ready     | i_rx_byte, i_end_of_frame
// report  | out       | o_out_valid / i_out_ready   | o_status ... o_frame_length
// config  | in        | APB psel/penable/pwrite     | paddr, pwdata, prdata
//
// One byte per cycle while no end-of-frame byte is held (see below): a byte is
// first held in the input register, then the combinational CRC/status logic
// updates the frame state and loads the report register with the frame's report.
// Synchronous active-low reset clears the frame state and sets own address to 1.
// A waiting report holds a following end-of-frame byte in the input register,
// which then stalls the input; other bytes keep flowing.
module modbus_rtu_frame_checker #(
    parameter int unsigned MAX_FRAME = mrtu_pkg::MAX_FRAME_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_end_of_frame,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_status,
    output logic [7:0]                       o_function_code,
    output logic                             o_is_broadcast,
    output logic [15:0]                      o_received_crc,
    output logic [15:0]                      o_computed_crc,
    output logic [7:0]                       o_payload_length,
    output logic [8:0]                       o_frame_length,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mrtu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mrtu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mrtu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    logic              r_in_valid;
    logic [7:0]        r_rx_byte;
    logic              r_eof;
    logic              r_out_valid;
    mrtu_pkg::t_result r_result;
    mrtu_pkg::t_result w_result;
    logic [7:0]        w_own_address;
    logic              w_step;

    mrtu_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_own_address (w_own_address)
    );

    mrtu_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_rx_byte      (r_rx_byte),
        .i_end_of_frame (r_eof),
        .i_own_address  (w_own_address),
        .o_result       (w_result)
    );

    // Process the held byte unless it ends a frame and the report slot is busy
    assign w_step     = r_in_valid && (!r_eof || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_rx_byte <= i_rx_byte;
            r_eof     <= i_end_of_frame;
        end
    end

    // Report register: load on a frame end, drop once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_eof) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_eof) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_result.status;
    assign o_function_code  = r_result.function_code;
    assign o_is_broadcast   = r_result.is_broadcast;
    assign o_received_crc   = r_result.received_crc;
    assign o_computed_crc   = r_result.computed_crc;
    assign o_payload_length = r_result.payload_length;
    assign o_frame_length   = r_result.frame_length;

endmodule
